/* hw/rtl/bls_pkg.sv */
// Shared types, widths and constants for the battery level smoother.
`timescale 1ns / 1ps

package bls_pkg;

	localparam int RAW_W       = 12;
	localparam int MV_W        = 13;
	localparam int PCT_W       = 7;
	localparam int SUM_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	localparam int SAMPLES_DEF = 10;

	localparam int DIV_NUM_W   = 24;
	localparam int DIV_DEN_W   = 13;

	localparam logic [MV_W-1:0]  FULL_RESET  = 13'd4150;
	localparam logic [MV_W-1:0]  EMPTY_RESET = 13'd3300;
	localparam logic [11:0]      PIN_MV_FS   = 12'd3300;
	localparam logic [11:0]      ADC_FS      = 12'd4095;
	localparam logic [3:0]       EMA_DEN     = 4'd10;
	localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV = 1'b1;

	typedef struct packed {
		logic [RAW_W-1:0] raw_sample;
		logic             sample_ok;
	} in_item_t;

	typedef struct packed {
		logic [MV_W-1:0]  measured_mv;
		logic [MV_W-1:0]  smoothed_mv;
		logic [PCT_W-1:0] level_percent;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* hw/rtl/bls_sdiv.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bls_sdiv (
	input  logic           clk,
	input  logic           arst_n,
	input  bls_pkg::div_req_t req,
	output bls_pkg::div_rsp_t rsp
);
	import bls_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W+1:0] diff;
	logic                 qbit;

	always_comb begin
		rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		qbit   = ~diff[DIV_DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

/* hw/rtl/battery_level_smoother.sv */
// Battery level smoother: sample averaging, millivolt scaling, EMA and level.
// A sample that does not close a group only updates the running sum and sample count.
// The closing sample starts two to four divisions that run one after another on one shared
// bit-serial divider, each made of an issue, a load and one step per quotient bit.
// Throughput: one sample per cycle inside a group; input stalls from the closing sample until its result is registered.
// Reset clears the sum, count and average; the full and empty thresholds take their defaults.
`timescale 1ns / 1ps

module battery_level_smoother #(
	parameter int SAMPLES_PER_READING = bls_pkg::SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bls_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bls_pkg::out_item_t                  out_item,
	input  logic                                cfg_we,
	input  logic [bls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bls_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bls_pkg::*;

	localparam int IDX_W = $clog2(SAMPLES_PER_READING + 1);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_AVG     = 7'b0000010,
		S_MV      = 7'b0000100,
		S_EMA     = 7'b0001000,
		S_LVL_SET = 7'b0010000,
		S_LVL     = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0] idx_q;
	logic [MV_W-1:0]  avg_q;
	logic [MV_W-1:0]  meas_q;
	logic [PCT_W-1:0] lvl_q;
	logic [MV_W-1:0]  full_q;
	logic [MV_W-1:0]  empty_q;
	out_item_t        out_q;
	logic             out_valid_q;
	div_req_t         div_req_q;
	div_rsp_t         div_rsp;

	logic [SUM_W-1:0] sum_next;
	logic [IDX_W-1:0] idx_next;
	logic [MV_W-1:0]  meas_new;
	logic             accept;

	bls_sdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		sum_next = in_item.sample_ok ? sum_q + SUM_W'(in_item.raw_sample) : sum_q;
		idx_next = idx_q + 1'b1;
		meas_new = {div_rsp.quotient[RAW_W-1:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= FULL_RESET;
			empty_q <= EMPTY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FULL_MV:  full_q  <= cfg_data;
				CFG_EMPTY_MV: empty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			sum_q           <= '0;
			idx_q           <= '0;
			avg_q           <= '0;
			out_valid_q     <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (idx_next == IDX_W'(SAMPLES_PER_READING)) begin
							sum_q     <= '0;
							idx_q     <= '0;
							div_req_q <= '{1'b1, DIV_NUM_W'(sum_next),
								DIV_DEN_W'(SAMPLES_PER_READING)};
							state_q   <= S_AVG;
						end else begin
							sum_q <= sum_next;
							idx_q <= idx_next;
						end
					end
				end
				S_AVG: begin
					if (div_rsp.done) begin
						div_req_q <= '{1'b1,
							DIV_NUM_W'(div_rsp.quotient[RAW_W-1:0]) * DIV_NUM_W'(PIN_MV_FS),
							DIV_DEN_W'(ADC_FS)};
						state_q   <= S_MV;
					end
				end
				S_MV: begin
					if (div_rsp.done) begin
						meas_q <= meas_new;
						if (meas_new == '0) begin
							state_q <= S_LVL_SET;
						end else if (avg_q == '0) begin
							avg_q   <= meas_new;
							state_q <= S_LVL_SET;
						end else begin
							div_req_q <= '{1'b1,
								(DIV_NUM_W'(avg_q) << 3) + (DIV_NUM_W'(meas_new) << 1),
								DIV_DEN_W'(EMA_DEN)};
							state_q   <= S_EMA;
						end
					end
				end
				S_EMA: begin
					if (div_rsp.done) begin
						avg_q   <= div_rsp.quotient[MV_W-1:0];
						state_q <= S_LVL_SET;
					end
				end
				S_LVL_SET: begin
					if (avg_q == '0) begin
						lvl_q   <= '0;
						state_q <= S_DONE;
					end else if (avg_q >= full_q) begin
						lvl_q   <= PCT_FULL;
						state_q <= S_DONE;
					end else if (avg_q <= empty_q) begin
						lvl_q   <= '0;
						state_q <= S_DONE;
					end else begin
						div_req_q <= '{1'b1,
							DIV_NUM_W'(avg_q - empty_q) * DIV_NUM_W'(PCT_FULL),
							full_q - empty_q};
						state_q   <= S_LVL;
					end
				end
				S_LVL: begin
					if (div_rsp.done) begin
						lvl_q   <= div_rsp.quotient[PCT_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= '{meas_q, avg_q, lvl_q};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/bls_checker.sv */
// Port-level checks for the battery level smoother, bound to the top level.
`timescale 1ns / 1ps

module bls_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input bls_pkg::out_item_t             out_item
);
	import bls_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.level_percent <= PCT_FULL)
		else $error("level above full scale");

	a_meas_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.measured_mv[0] == 1'b0)
		else $error("measured voltage not doubled");

	a_unseeded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.smoothed_mv == '0 |->
			out_item.level_percent == '0 && out_item.measured_mv == '0)
		else $error("unseeded average with nonzero reading");

endmodule

bind battery_level_smoother bls_checker u_bls_checker (.*);
